// File: src/krs_pkg.sv
// Shared types and constants for the keyed record stack.
// Holds word structs, operation codes and controller/datapath link structs.
// No dependencies.
package krs_pkg;

	localparam int DEPTH   = 64;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = 7;
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);
	localparam logic             REG_CAPACITY = 1'b0;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_PEEK   = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef struct packed {
		op_t                       operation;
		logic signed [DATA_W-1:0]  entry_id;
		logic        [DATA_W-1:0]  entry_payload;
	} req_word_t;

	typedef struct packed {
		logic                      ok;
		logic signed [DATA_W-1:0]  out_id;
		logic        [DATA_W-1:0]  out_payload;
		logic        [CNT_W-1:0]   fill_count;
		logic                      is_empty;
		logic                      is_full;
	} rsp_word_t;

	typedef struct packed {
		logic take;
		logic push;
		logic fail;
		logic rd_top;
		logic hit;
		logic dec_fill;
		logic search_start;
		logic search_next;
		logic shift_rd;
		logic shift_wr;
		logic emit;
	} krs_cmd_t;

	typedef struct packed {
		op_t  op;
		logic empty;
		logic match;
		logic idx_zero;
		logic idx_top;
		logic shift_last;
		logic out_free;
	} krs_sts_t;

endpackage

// File: src/krs_ctrl.sv
// Controller state machine for the keyed record stack.
// Sequences push, pop/peek, search and shift; drives commands to krs_dpath.
// Depends on krs_pkg.
module krs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  krs_pkg::krs_sts_t sts,
	output krs_pkg::krs_cmd_t cmd
);
	import krs_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_EXEC   = 7'b0000010,
		S_TOP    = 7'b0000100,
		S_SEARCH = 7'b0001000,
		S_SHRD   = 7'b0010000,
		S_SHWR   = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				case (sts.op)
					OP_PUSH: begin
						cmd.push = 1'b1;
						state_d  = S_DONE;
					end
					OP_POP, OP_PEEK: begin
						if (sts.empty) begin
							cmd.fail = 1'b1;
							state_d  = S_DONE;
						end else begin
							cmd.rd_top = 1'b1;
							state_d    = S_TOP;
						end
					end
					default: begin
						if (sts.empty) begin
							cmd.fail = 1'b1;
							state_d  = S_DONE;
						end else begin
							cmd.search_start = 1'b1;
							state_d          = S_SEARCH;
						end
					end
				endcase
			end
			S_TOP: begin
				cmd.hit      = 1'b1;
				cmd.dec_fill = (sts.op == OP_POP);
				state_d      = S_DONE;
			end
			S_SEARCH: begin
				if (sts.match) begin
					cmd.hit = 1'b1;
					if (sts.idx_top) begin
						cmd.dec_fill = 1'b1;
						state_d      = S_DONE;
					end else begin
						state_d = S_SHRD;
					end
				end else if (sts.idx_zero) begin
					cmd.fail = 1'b1;
					state_d  = S_DONE;
				end else begin
					cmd.search_next = 1'b1;
				end
			end
			S_SHRD: begin
				cmd.shift_rd = 1'b1;
				state_d      = S_SHWR;
			end
			S_SHWR: begin
				cmd.shift_wr = 1'b1;
				if (sts.shift_last) begin
					cmd.dec_fill = 1'b1;
					state_d      = S_DONE;
				end else begin
					state_d = S_SHRD;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: src/krs_dpath.sv
// Datapath for the keyed record stack: record memory, fill count,
// search index, item and result registers. Acts on krs_ctrl commands.
// Depends on krs_pkg.
module krs_dpath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  krs_pkg::req_word_t       req,
	input  logic [krs_pkg::CNT_W-1:0] capacity,
	input  logic                     rsp_stall,
	output logic                     rsp_valid,
	output krs_pkg::rsp_word_t       rsp,
	input  krs_pkg::krs_cmd_t        cmd,
	output krs_pkg::krs_sts_t        sts
);
	import krs_pkg::*;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	logic [2*DATA_W-1:0] mem_q [DEPTH];
	logic [2*DATA_W-1:0] rd_data_q;

	op_t                 op_q;
	logic [DATA_W-1:0]   key_q;
	logic [DATA_W-1:0]   pay_q;
	logic [CNT_W-1:0]    fill_q;
	logic [ADDR_W-1:0]   idx_q;
	logic                ok_q;
	logic [DATA_W-1:0]   rid_q;
	logic [DATA_W-1:0]   rpay_q;
	logic                rsp_valid_q;
	rsp_word_t           rsp_q;

	logic [CNT_W-1:0]    eff_cap;
	logic                push_ok;
	logic [ADDR_W-1:0]   top_addr;
	logic [ADDR_W-1:0]   rd_addr;
	logic                rd_en;
	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	logic [2*DATA_W-1:0] wr_data;

	assign eff_cap  = (capacity > DEPTH_CNT) ? DEPTH_CNT : capacity;
	assign push_ok  = (fill_q < eff_cap);
	assign top_addr = ADDR_W'(fill_q - CNT_W'(1));

	always_comb begin
		rd_addr = top_addr;
		if (cmd.search_next) begin
			rd_addr = idx_q - ADDR_W'(1);
		end else if (cmd.shift_rd) begin
			rd_addr = idx_q + ADDR_W'(1);
		end
	end

	assign rd_en = cmd.rd_top | cmd.search_start | cmd.search_next | cmd.shift_rd;

	assign wr_en   = (cmd.push & push_ok) | cmd.shift_wr;
	assign wr_addr = cmd.shift_wr ? idx_q : ADDR_W'(fill_q);
	assign wr_data = cmd.shift_wr ? rd_data_q : {key_q, pay_q};

	// record memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q  <= req.operation;
			key_q <= req.entry_id;
			pay_q <= req.entry_payload;
		end
		if (cmd.search_start) begin
			idx_q <= top_addr;
		end else if (cmd.search_next) begin
			idx_q <= idx_q - ADDR_W'(1);
		end else if (cmd.shift_wr) begin
			idx_q <= idx_q + ADDR_W'(1);
		end
		if (cmd.push) begin
			ok_q   <= push_ok;
			rid_q  <= '0;
			rpay_q <= '0;
		end else if (cmd.fail) begin
			ok_q   <= 1'b0;
			rid_q  <= '0;
			rpay_q <= '0;
		end else if (cmd.hit) begin
			ok_q   <= 1'b1;
			rid_q  <= rd_data_q[2*DATA_W-1:DATA_W];
			rpay_q <= rd_data_q[DATA_W-1:0];
		end
		if (cmd.emit) begin
			rsp_q.ok          <= ok_q;
			rsp_q.out_id      <= rid_q;
			rsp_q.out_payload <= rpay_q;
			rsp_q.fill_count  <= fill_q;
			rsp_q.is_empty    <= (fill_q == '0);
			rsp_q.is_full     <= (fill_q >= eff_cap);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.push && push_ok) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (cmd.dec_fill) begin
				fill_q <= fill_q - CNT_W'(1);
			end
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign sts.op         = op_q;
	assign sts.empty      = (fill_q == '0);
	assign sts.match      = (rd_data_q[2*DATA_W-1:DATA_W] == key_q);
	assign sts.idx_zero   = (idx_q == '0);
	assign sts.idx_top    = ((CNT_W'(idx_q) + CNT_W'(1)) == fill_q);
	assign sts.shift_last = ((CNT_W'(idx_q) + CNT_W'(2)) == fill_q);
	assign sts.out_free   = !rsp_valid_q || !rsp_stall;

endmodule

// File: src/keyed_record_stack_core.sv
// Top level of the keyed record stack: APB capacity register,
// controller and datapath. Depends on krs_pkg, krs_ctrl, krs_dpath.
//
// Usage: a request word (operation, entry_id, entry_payload) is taken on
// req when req_valid is high and req_stall low; one response word per
// request leaves on rsp (ok, out_id, out_payload, fill_count, is_empty,
// is_full) under rsp_valid/rsp_stall. One request is in progress at a
// time; req_stall is high from acceptance until its response is loaded.
// After acceptance a push goes from S_EXEC to S_DONE; a pop or peek reads
// the top record in S_TOP (an empty stack fails straight to S_DONE, as
// does a remove); a remove scans records from the top down in S_SEARCH
// until a hit (or all of them on a miss), then closes the gap by moving
// each record above the hit down, a read in S_SHRD and a write in S_SHWR.
// The response is loaded in S_DONE; req_stall drops as it is loaded, and
// only then is a new request taken. The response register holds a word
// while rsp_stall is high; the next request is accepted meanwhile and
// waits for the register to free. Capacity (APB address 0, reset 64) is
// to be written only while idle; the block itself does not enforce it.
// Reset empties the stack and clears the handshakes; memory is not cleared.
module keyed_record_stack_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  krs_pkg::req_word_t           req,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output krs_pkg::rsp_word_t           rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [krs_pkg::PADDR_W-1:0]  paddr,
	input  logic [krs_pkg::PDATA_W-1:0]  pwdata,
	output logic [krs_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import krs_pkg::*;

	logic [CNT_W-1:0] capacity_q;
	krs_cmd_t         cmd;
	krs_sts_t         sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
			capacity_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity_q) : '0;

	krs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	krs_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.capacity  (capacity_q),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
